@@ design/stpseq_pkg.sv @@
// Shared types, codes and constants for the stepper position sequencer.
// Holds the coil drive tables; no dependencies.
package stpseq_pkg;

    // request codes carried in the input kind field
    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_MOVE      = 3'd1,
        REQ_JOG_UP    = 3'd2,
        REQ_JOG_DOWN  = 3'd3,
        REQ_CALIBRATE = 3'd4
    } req_type_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_BUSY  = 2'd2,
        STATUS_LIMIT = 2'd3
    } status_t;

    // drive modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_WAVE   = 2'd1,
        MODE_HALF   = 2'd2
    } drive_mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DRIVE_MODE   = 2'd0,
        CFG_HEIGHT_LIMIT = 2'd1,
        CFG_JOG_STEPS    = 2'd2
    } cfg_index_t;

    localparam int REQ_W        = 3;
    localparam int PERCENT_W    = 7;
    localparam int MODE_W       = 2;
    localparam int HEIGHT_W     = 20;
    localparam int JOG_W        = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int COIL_W       = 4;

    localparam logic [PERCENT_W-1:0] PERCENT_FULL_SCALE = 7'd100;
    localparam logic [HEIGHT_W-1:0]  HEIGHT_LIMIT_RESET = 20'd4096;
    localparam logic [JOG_W-1:0]     JOG_STEPS_RESET    = 16'd64;

    // command tag that travels down the pipeline beside the target
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             pct_bad;
    } stpseq_cmd_t;

    // coil pattern for a drive mode and the low bits of the position
    function automatic logic [COIL_W-1:0] coil_pattern_f(input logic [MODE_W-1:0] mode,
                                                          input logic [2:0] phase);
        logic [COIL_W-1:0] pat;
        case (mode)
            MODE_WAVE: begin
                case (phase[1:0])
                    2'd0:    pat = 4'h1;
                    2'd1:    pat = 4'h2;
                    2'd2:    pat = 4'h4;
                    default: pat = 4'h8;
                endcase
            end
            MODE_HALF: begin
                case (phase)
                    3'd0:    pat = 4'h1;
                    3'd1:    pat = 4'h3;
                    3'd2:    pat = 4'h2;
                    3'd3:    pat = 4'h6;
                    3'd4:    pat = 4'h4;
                    3'd5:    pat = 4'hC;
                    3'd6:    pat = 4'h8;
                    default: pat = 4'h9;
                endcase
            end
            default: begin
                case (phase[1:0])
                    2'd0:    pat = 4'h3;
                    2'd1:    pat = 4'h6;
                    2'd2:    pat = 4'hC;
                    default: pat = 4'h9;
                endcase
            end
        endcase
        return pat;
    endfunction

endpackage

@@ design/stepper_position_sequencer.sv @@
// Stepper position sequencer: top level with the configuration registers,
// pipeline flow control and result packing. Depends on stpseq_pkg,
// stpseq_target and stpseq_motion.
//
// Usage:
//   The input stream carries one event per transfer: the request kind on
//   s_axis_tuser and the move percent on s_axis_tdata. Every event gives
//   exactly one result transfer on the m_axis side with the coil pattern,
//   step flag, position, moving flag and status.
//   One event can be taken every cycle while the receiver does not stall; the
//   pipeline is five registers deep (percent product, two reciprocal stages,
//   quotient correction, then the motion state and result register).
//   When the receiver stalls, the whole pipeline holds and s_axis_tready
//   drops until the waiting result is taken; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline, zeroes position,
//   pending steps, direction and coils, and restores the configuration
//   defaults (normal drive, limit 4096, jog 64). Configuration writes
//   are taken on any cycle with cfg_wr_en high.
module stepper_position_sequencer
    import stpseq_pkg::*;
#(
    parameter int POSITION_BITS = 20
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration writes
    input  logic                                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                  cfg_addr,
    input  logic [CFG_DATA_W-1:0]                  cfg_wr_data,
    // event stream in
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,  // [6:0] percent
    input  logic [REQ_W-1:0]                       s_axis_tuser,  // [2:0] req_type
    // result stream out
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [3:0] coil_pattern, [4] coil_stepped, [POSITION_BITS+4:5] position,
    // then moving, then status (2 bits), zero padded to whole bytes
    output logic [((POSITION_BITS+15)/8)*8-1:0]    m_axis_tdata
);

    localparam int DW = ((POSITION_BITS + 15) / 8) * 8;
    localparam int CW = (POSITION_BITS > HEIGHT_W) ? POSITION_BITS : HEIGHT_W;

    logic [MODE_W-1:0]   drive_mode_reg;
    logic [HEIGHT_W-1:0] height_limit_reg;
    logic [JOG_W-1:0]    jog_steps_reg;

    logic                     en;
    logic                     m_valid_reg;
    stpseq_cmd_t              in_cmd;
    logic [CW-1:0]            height_ext;
    logic [CW-1:0]            pos_max_ext;
    logic [POSITION_BITS-1:0] eff_limit;

    logic                     t_valid;
    stpseq_cmd_t              t_cmd;
    logic [POSITION_BITS-1:0] t_target;

    logic [COIL_W-1:0]        coil_pattern;
    logic                     coil_stepped;
    logic [POSITION_BITS-1:0] position;
    logic                     moving;
    logic [1:0]               status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg   <= MODE_NORMAL;
            height_limit_reg <= HEIGHT_LIMIT_RESET;
            jog_steps_reg    <= JOG_STEPS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DRIVE_MODE:   drive_mode_reg   <= cfg_wr_data[MODE_W-1:0];
                CFG_HEIGHT_LIMIT: height_limit_reg <= cfg_wr_data[HEIGHT_W-1:0];
                CFG_JOG_STEPS:    jog_steps_reg    <= cfg_wr_data[JOG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // height limit capped at the largest position
    assign height_ext  = CW'(height_limit_reg);
    assign pos_max_ext = CW'({POSITION_BITS{1'b1}});
    assign eff_limit   = (height_ext > pos_max_ext) ? pos_max_ext[POSITION_BITS-1:0]
                                                    : height_ext[POSITION_BITS-1:0];

    // whole pipeline advances whenever the result register is free or being read
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign in_cmd.req_type = s_axis_tuser;
    assign in_cmd.pct_bad  = s_axis_tdata[PERCENT_W-1:0] > PERCENT_FULL_SCALE;

    stpseq_target #(
        .POSITION_BITS (POSITION_BITS)
    ) u_target (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .in_cmd     (in_cmd),
        .in_percent (s_axis_tdata[PERCENT_W-1:0]),
        .eff_limit  (eff_limit),
        .out_valid  (t_valid),
        .out_cmd    (t_cmd),
        .out_target (t_target)
    );

    stpseq_motion #(
        .POSITION_BITS (POSITION_BITS)
    ) u_motion (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (en && t_valid),
        .cmd          (t_cmd),
        .target       (t_target),
        .drive_mode   (drive_mode_reg),
        .eff_limit    (eff_limit),
        .jog_steps    (jog_steps_reg),
        .coil_pattern (coil_pattern),
        .coil_stepped (coil_stepped),
        .position     (position),
        .moving       (moving),
        .status       (status)
    );

    // result valid follows the last pipeline stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= t_valid;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DW'({status, moving, position, coil_stepped, coil_pattern});

endmodule

@@ design/stpseq_target.sv @@
// Four-stage pipeline that turns a height percent into a target step position:
// limit * percent, then a reciprocal multiply for the divide by 100, then a correction.
// Depends on stpseq_pkg.
module stpseq_target
    import stpseq_pkg::*;
#(
    parameter int POSITION_BITS = 20
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  stpseq_cmd_t                in_cmd,
    input  logic [PERCENT_W-1:0]       in_percent,
    input  logic [POSITION_BITS-1:0]   eff_limit,
    output logic                       out_valid,
    output stpseq_cmd_t                out_cmd,
    output logic [POSITION_BITS-1:0]   out_target
);

    // product width, split point and reciprocal of 100 scaled by 2^PW
    localparam int PW = POSITION_BITS + PERCENT_W;
    localparam int H  = PW / 2;
    localparam int MW = POSITION_BITS + 1;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << PW) / 64'd100);
    localparam logic [PW-1:0] DIVISOR = PW'(100);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    stpseq_cmd_t        cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;
    logic [PW-1:0]      p1_reg, p2_reg, p3_reg;
    logic [PW-H+MW-1:0] pp_hi_reg;
    logic [H+MW-1:0]    pp_lo_reg;
    logic [MW-1:0]      q3_reg;
    logic [POSITION_BITS-1:0] target4_reg;

    logic [PW-1:0]      p1_next;
    logic [PW-H+MW-1:0] pp_hi_next;
    logic [H+MW-1:0]    pp_lo_next;
    logic [PW+MW-1:0]   prod_sum;
    logic [MW-1:0]      q3_next;
    logic [PW-1:0]      rem;
    logic [MW-1:0]      q_fix;
    logic [POSITION_BITS-1:0] target4_next;

    // stage 1: limit times percent
    assign p1_next = PW'(eff_limit) * PW'(in_percent);

    // stage 2: two partial products against the reciprocal
    assign pp_hi_next = (PW-H+MW)'(p1_reg[PW-1:H]) * (PW-H+MW)'(RECIP);
    assign pp_lo_next = (H+MW)'(p1_reg[H-1:0]) * (H+MW)'(RECIP);

    // stage 3: quotient estimate, never more than one below the true value
    assign prod_sum = {pp_hi_reg, {H{1'b0}}} + (PW+MW)'(pp_lo_reg);
    assign q3_next  = prod_sum[PW+MW-1:PW];

    // stage 4: remainder check and correction
    assign rem          = p3_reg - PW'(q3_reg) * DIVISOR;
    assign q_fix        = q3_reg + ((rem >= DIVISOR) ? MW'(1) : MW'(0));
    assign target4_next = q_fix[POSITION_BITS-1:0];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg    <= in_cmd;
            p1_reg      <= p1_next;
            cmd2_reg    <= cmd1_reg;
            p2_reg      <= p1_reg;
            pp_hi_reg   <= pp_hi_next;
            pp_lo_reg   <= pp_lo_next;
            cmd3_reg    <= cmd2_reg;
            p3_reg      <= p2_reg;
            q3_reg      <= q3_next;
            cmd4_reg    <= cmd3_reg;
            target4_reg <= target4_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_cmd    = cmd4_reg;
    assign out_target = target4_reg;

endmodule

@@ design/stpseq_motion.sv @@
// Motion state and result register: position, pending steps, direction and coils,
// updated once per item as it enters the result register. Depends on stpseq_pkg.
module stpseq_motion
    import stpseq_pkg::*;
#(
    parameter int POSITION_BITS = 20
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  stpseq_cmd_t                cmd,
    input  logic [POSITION_BITS-1:0]   target,
    input  logic [MODE_W-1:0]          drive_mode,
    input  logic [POSITION_BITS-1:0]   eff_limit,
    input  logic [JOG_W-1:0]           jog_steps,
    output logic [COIL_W-1:0]          coil_pattern,
    output logic                       coil_stepped,
    output logic [POSITION_BITS-1:0]   position,
    output logic                       moving,
    output logic [1:0]                 status
);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] rem_reg, rem_next;
    logic                     dir_reg, dir_next;
    logic [COIL_W-1:0]        coil_reg, coil_next;
    logic                     stepped_reg, stepped_next;
    status_t                  status_reg, status_next;

    logic                     busy;
    logic                     blocked;
    logic [POSITION_BITS-1:0] pos_step;

    // one step in the current direction, refused at either end
    assign busy     = rem_reg != '0;
    assign blocked  = dir_reg ? (pos_reg == '0) : (pos_reg >= eff_limit);
    assign pos_step = dir_reg ? (pos_reg - POSITION_BITS'(1)) : (pos_reg + POSITION_BITS'(1));

    // command decode
    always_comb begin
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        dir_next     = dir_reg;
        coil_next    = coil_reg;
        stepped_next = 1'b0;
        status_next  = STATUS_OK;
        case (cmd.req_type)
            REQ_TICK: begin
                if (busy) begin
                    if (blocked) begin
                        rem_next    = '0;
                        status_next = STATUS_LIMIT;
                    end else begin
                        pos_next     = pos_step;
                        coil_next    = coil_pattern_f(drive_mode, pos_step[2:0]);
                        rem_next     = rem_reg - POSITION_BITS'(1);
                        stepped_next = 1'b1;
                    end
                end
            end
            REQ_MOVE: begin
                if (busy) begin
                    status_next = STATUS_BUSY;
                end else if (cmd.pct_bad) begin
                    status_next = STATUS_RANGE;
                end else if (target > pos_reg) begin
                    rem_next = target - pos_reg;
                    dir_next = 1'b0;
                end else begin
                    rem_next = pos_reg - target;
                    dir_next = 1'b1;
                end
            end
            REQ_JOG_UP, REQ_JOG_DOWN: begin
                if (busy) begin
                    status_next = STATUS_BUSY;
                end else begin
                    rem_next = POSITION_BITS'(jog_steps);
                    dir_next = (cmd.req_type == REQ_JOG_DOWN);
                end
            end
            REQ_CALIBRATE: begin
                pos_next = '0;
                rem_next = '0;
            end
            default: begin
            end
        endcase
    end

    // motion state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            rem_reg  <= '0;
            dir_reg  <= 1'b0;
            coil_reg <= '0;
        end else if (load) begin
            pos_reg  <= pos_next;
            rem_reg  <= rem_next;
            dir_reg  <= dir_next;
            coil_reg <= coil_next;
        end
    end

    // per-item result flags
    always_ff @(posedge aclk) begin
        if (load) begin
            stepped_reg <= stepped_next;
            status_reg  <= status_next;
        end
    end

    assign coil_pattern = coil_reg;
    assign coil_stepped = stepped_reg;
    assign position     = pos_reg;
    assign moving       = busy;
    assign status       = status_reg;

    // a step is only ever reported with an ok status
    a_step_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> !(stepped_reg && status_reg != STATUS_OK))
        else $error("step reported with a non-ok status");

    // a limit stop leaves nothing pending
    a_limit_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (status_reg != STATUS_LIMIT || rem_reg == '0))
        else $error("limit status with steps still pending");

    // a reported step moves the position by exactly one
    a_step_one: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (!stepped_reg || pos_reg == $past(pos_reg) + POSITION_BITS'(1)
                  || pos_reg == $past(pos_reg) - POSITION_BITS'(1)))
        else $error("step moved position by more than one");

    // calibrate parks at zero with no move pending
    a_calibrate: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cmd.req_type == REQ_CALIBRATE) |=> (pos_reg == '0 && rem_reg == '0))
        else $error("calibrate did not clear position");

endmodule

@@ tb/sv/stepper_position_sequencer_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the stepper position sequencer: watches the event and result
// streams and the register writes, predicts each result and compares it. Depends on stpseq_pkg.
module stepper_position_sequencer_checker
    import stpseq_pkg::*;
#(
    parameter int POS_W   = 20,
    parameter int TDATA_W = ((POS_W + 15) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [6:0] percent
    input  logic [REQ_W-1:0]      s_axis_tuser,   // [2:0] req_type
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] coil_pattern, [4] coil_stepped, [POS_W+4:5] position, then moving, then status
    input  logic [TDATA_W-1:0]    m_axis_tdata,
    output int                    pending_results,
    output int                    fail_count
);

    localparam int PAD_LO = POS_W + 8;
    localparam int PROD_W = HEIGHT_W + PERCENT_W;

    // coil sequences packed four bits per phase, phase 0 in the lowest nibble
    localparam logic [15:0] NORMAL_SEQ = 16'h9C63;
    localparam logic [15:0] WAVE_SEQ   = 16'h8421;
    localparam logic [31:0] HALF_SEQ   = 32'h98C46231;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              stepped;
        logic [POS_W-1:0]  position;
        logic              moving;
        status_t           status;
    } blind_result_t;

    blind_result_t expected_q[$];
    int            mismatches = 0;
    int            queue_depth = 0;

    // register copies
    logic [MODE_W-1:0]   drive_mode;
    logic [HEIGHT_W-1:0] height_limit;
    logic [JOG_W-1:0]    jog_count;

    // motor state
    logic [POS_W-1:0]    step_pos;
    logic [POS_W-1:0]    steps_left;
    logic                reverse;
    logic [COIL_W-1:0]   coils;

    assign pending_results = queue_depth;
    assign fail_count      = mismatches;

    // pattern for a position under the current drive mode; the spare mode drives normally
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [POS_W-1:0] pos);
        case (drive_mode)
            MODE_WAVE: return WAVE_SEQ[{pos[1:0], 2'b00} +: 4];
            MODE_HALF: return HALF_SEQ[{pos[2:0], 2'b00} +: 4];
            default:   return NORMAL_SEQ[{pos[1:0], 2'b00} +: 4];
        endcase
    endfunction

    // apply one event to the motor state and build the result it gives
    function automatic blind_result_t advance_blind(input logic [REQ_W-1:0] kind,
                                                    input logic [PERCENT_W-1:0] pct);
        blind_result_t                res;
        logic                         busy;
        logic                         blocked;
        logic [PROD_W-1:0]            product;
        logic [POS_W-1:0]             target;
        res.stepped = 1'b0;
        res.status  = STATUS_OK;
        busy = steps_left != '0;
        case (kind)
            REQ_TICK: begin
                if (busy) begin
                    // the limit never exceeds the position range at this width
                    blocked = reverse ? (step_pos == '0) : (step_pos >= height_limit);
                    if (blocked) begin
                        steps_left = '0;
                        res.status = STATUS_LIMIT;
                    end else begin
                        step_pos    = reverse ? step_pos - POS_W'(1) : step_pos + POS_W'(1);
                        coils       = coil_lookup(step_pos);
                        steps_left  = steps_left - POS_W'(1);
                        res.stepped = 1'b1;
                    end
                end
            end
            REQ_MOVE: begin
                if (busy) begin
                    res.status = STATUS_BUSY;
                end else if (pct > PERCENT_FULL_SCALE) begin
                    res.status = STATUS_RANGE;
                end else begin
                    product = PROD_W'(height_limit) * PROD_W'(pct);
                    target  = POS_W'(product / PROD_W'(PERCENT_FULL_SCALE));
                    if (target > step_pos) begin
                        steps_left = target - step_pos;
                        reverse    = 1'b0;
                    end else begin
                        steps_left = step_pos - target;
                        reverse    = 1'b1;
                    end
                end
            end
            REQ_JOG_UP, REQ_JOG_DOWN: begin
                if (busy) begin
                    res.status = STATUS_BUSY;
                end else begin
                    steps_left = POS_W'(jog_count);
                    reverse    = kind == REQ_JOG_DOWN;
                end
            end
            REQ_CALIBRATE: begin
                step_pos   = '0;
                steps_left = '0;
            end
            default: ;
        endcase
        res.coils    = coils;
        res.position = step_pos;
        res.moving   = steps_left != '0;
        return res;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // compare one result transfer with the oldest prediction
    task automatic check_result(input logic [TDATA_W-1:0] beat);
        blind_result_t want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual 0x%0h",
                     $time, beat);
            mismatches++;
        end else begin
            want = expected_q.pop_front();
            check_field("coil_pattern", 32'(want.coils), 32'(beat[3:0]));
            check_field("coil_stepped", 32'(want.stepped), 32'(beat[4]));
            check_field("position", 32'(want.position), 32'(beat[POS_W+4:5]));
            check_field("moving", 32'(want.moving), 32'(beat[POS_W+5]));
            check_field("status", 32'(want.status), 32'(beat[POS_W+7:POS_W+6]));
            check_field("padding", 32'd0, 32'(beat[TDATA_W-1:PAD_LO]));
        end
    endtask

    // sample every transfer at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode   = MODE_NORMAL;
            height_limit = HEIGHT_LIMIT_RESET;
            jog_count    = JOG_STEPS_RESET;
            step_pos     = '0;
            steps_left   = '0;
            reverse      = 1'b0;
            coils        = '0;
            expected_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DRIVE_MODE:   drive_mode   = cfg_wr_data[MODE_W-1:0];
                    CFG_HEIGHT_LIMIT: height_limit = cfg_wr_data[HEIGHT_W-1:0];
                    CFG_JOG_STEPS:    jog_count    = cfg_wr_data[JOG_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(advance_blind(s_axis_tuser, s_axis_tdata[PERCENT_W-1:0]));
        end
        queue_depth = expected_q.size();
    end

endmodule

@@ tb/sv/stepper_position_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the stepper position sequencer: clock, reset, event stimulus,
// result back-pressure and verdict. Depends on stpseq_pkg and the checker module.
module stepper_position_sequencer_tb;
    import stpseq_pkg::*;

    localparam int POS_W            = 20;
    localparam int TDATA_W          = ((POS_W + 15) / 8) * 8;
    localparam int PHASES           = 8;
    localparam int EVENTS_PER_PHASE = 235;
    localparam int LONG_HOLD        = 80;
    localparam int HOLD_AFTER       = 400;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 12;

    // request codes the block treats as no-ops, and the spare drive mode
    localparam logic [REQ_W-1:0]  REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0]  REQ_SPARE_LAST  = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE      = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [6:0] percent
    logic [REQ_W-1:0]      s_axis_tuser;   // [2:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [3:0] coil_pattern, [4] coil_stepped, [24:5] position, [25] moving, [27:26] status
    logic [TDATA_W-1:0]    m_axis_tdata;

    int pending_results;
    int fail_count;
    int cycle_count = 0;
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;

    stepper_position_sequencer #(
        .POSITION_BITS (POS_W)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stepper_position_sequencer_checker #(
        .POS_W (POS_W)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random hold-off before each transfer, one long stall part way through
    initial begin : result_sink
        int wait_cycles;
        int taken;
        bit long_done;
        taken = 0;
        long_done = 1'b0;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            wait_cycles = receiver_quiet ? 0 : $urandom_range(0, 9);
            if (!long_done && taken >= HOLD_AFTER) begin
                wait_cycles = LONG_HOLD;
                long_done = 1'b1;
            end
            if (wait_cycles > 0) begin
                @(negedge aclk);
                m_axis_tready <= 1'b0;
                repeat (wait_cycles - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // offer one event after a random gap and hold it until the transfer
    task automatic send_event(input logic [REQ_W-1:0] kind, input logic [PERCENT_W-1:0] pct);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, pct};
        s_axis_tuser  <= kind;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly step ticks with commands between them, plus no-op codes
    task automatic send_random_event();
        int               pick;
        logic [REQ_W-1:0] kind;
        logic [PERCENT_W-1:0] pct;
        pick = $urandom_range(0, 99);
        pct  = PERCENT_W'($urandom_range(0, 127));
        if (pick < 68) begin
            kind = REQ_TICK;
        end else if (pick < 78) begin
            kind = REQ_MOVE;
            if ($urandom_range(0, 4) != 0)
                pct = PERCENT_W'($urandom_range(0, PERCENT_FULL_SCALE));
        end else if (pick < 84) begin
            kind = REQ_JOG_UP;
        end else if (pick < 90) begin
            kind = REQ_JOG_DOWN;
        end else if (pick < 94) begin
            kind = REQ_CALIBRATE;
        end else begin
            kind = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        end
        send_event(kind, pct);
    endtask

    // reset, directed events at the reset settings, then random phases
    initial begin : stimulus
        logic [MODE_W-1:0]   mode;
        logic [HEIGHT_W-1:0] limit;
        logic [JOG_W-1:0]    jog;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // idle tick, percent range, no-op move, refused step at zero
        send_event(REQ_TICK, 7'd0);
        send_event(REQ_MOVE, 7'd101);
        send_event(REQ_MOVE, 7'd127);
        send_event(REQ_MOVE, 7'd0);
        send_event(REQ_JOG_DOWN, 7'd0);
        send_event(REQ_TICK, 7'd0);
        // busy rejection while a jog runs, ignored codes, calibrate mid move
        send_event(REQ_JOG_UP, 7'd0);
        send_event(REQ_MOVE, 7'd50);
        send_event(REQ_JOG_DOWN, 7'd0);
        send_event(REQ_TICK, 7'd0);
        send_event(REQ_TICK, 7'd127);
        send_event(REQ_TICK, 7'd0);
        send_event(REQ_SPARE_FIRST, 7'd0);
        send_event(REQ_SPARE_FIRST + 3'd1, 7'd100);
        send_event(REQ_SPARE_LAST, 7'd127);
        send_event(REQ_CALIBRATE, 7'd0);
        // full height move, then the smallest one
        send_event(REQ_MOVE, 7'd100);
        send_event(REQ_TICK, 7'd0);
        send_event(REQ_TICK, 7'd0);
        send_event(REQ_CALIBRATE, 7'd0);
        send_event(REQ_MOVE, 7'd1);
        send_event(REQ_TICK, 7'd0);
        send_event(REQ_CALIBRATE, 7'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1:       begin mode = MODE_WAVE;   limit = 20'd200;   jog = 16'd16;    end
                    2:       begin mode = MODE_HALF;   limit = 20'd0;     jog = 16'd1;     end
                    3:       begin mode = MODE_SPARE;  limit = 20'hFFFFF; jog = 16'hFFFF;  end
                    4:       begin mode = MODE_NORMAL; limit = 20'd1;     jog = 16'd0;     end
                    5: begin
                        mode  = MODE_HALF;
                        limit = HEIGHT_W'($urandom_range(20, 300));
                        jog   = JOG_W'($urandom_range(1, 40));
                    end
                    6: begin
                        mode  = MODE_WAVE;
                        limit = HEIGHT_W'($urandom_range(0, 20'hFFFFF));
                        jog   = JOG_W'($urandom_range(1, 16'hFFFF));
                    end
                    default: begin mode = MODE_HALF;   limit = 20'd4096;  jog = 16'd64;    end
                endcase
                write_reg(CFG_DRIVE_MODE, CFG_DATA_W'(mode));
                write_reg(CFG_HEIGHT_LIMIT, CFG_DATA_W'(limit));
                write_reg(CFG_JOG_STEPS, CFG_DATA_W'(jog));
            end
            // some phases run back to back on one side or the other
            sender_quiet   = (phase % 3) == 1;
            receiver_quiet = (phase % 4) == 2;
            repeat (EVENTS_PER_PHASE) send_random_event();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/stpseq_pkg.sv
design/stpseq_target.sv
design/stpseq_motion.sv
design/stepper_position_sequencer.sv
tb/sv/stepper_position_sequencer_checker.sv
tb/sv/stepper_position_sequencer_tb.sv
